// File: sv/pwcs_pkg.sv
// shared widths and controller/datapath handshake types for the centroid sums block
`default_nettype none
package pwcs_pkg;

    localparam int XY_W  = 32;
    localparam int LEN_W = 63;
    localparam int ACC_W = 64;

    // commands from the controller to the datapath, at most one high per cycle
    typedef struct packed {
        logic accept;
        logic sq_x;
        logic sq_y;
        logic sq_sum;
        logic root_step;
        logic mul_x;
        logic mul_y;
        logic acc_y;
        logic load_out;
    } t_dp_cmd;

    // status from the datapath back to the controller
    typedef struct packed {
        logic seg;
        logic root_last;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: sv/pwcs_if.sv
// vertex and result channel interfaces
`default_nettype none
interface pwcs_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pwcs_pkg::XY_W-1:0]    x;
    logic signed [pwcs_pkg::XY_W-1:0]    y;
    logic                                start_line;
    logic                                clear_sums;

    modport source (output valid, x, y, start_line, clear_sums, input ready);
    modport sink   (input valid, x, y, start_line, clear_sums, output ready);
endinterface

interface pwcs_out_if;
    logic                                valid;
    logic                                ready;
    logic        [pwcs_pkg::LEN_W-1:0]   total_length;
    logic signed [pwcs_pkg::ACC_W-1:0]   weighted_x;
    logic signed [pwcs_pkg::ACC_W-1:0]   weighted_y;
    logic                                overflowed;

    modport source (output valid, total_length, weighted_x, weighted_y, overflowed,
                    input ready);
    modport sink   (input valid, total_length, weighted_x, weighted_y, overflowed,
                    output ready);
endinterface
`default_nettype wire

// File: sv/pwcs_ctrl.sv
// sequencing state machine for the centroid sums block
`default_nettype none
module pwcs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pwcs_pkg::t_dp_cmd      o_cmd,
    input  wire pwcs_pkg::t_dp_sts i_sts
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SQX   = 9'b000000010,
        S_SQY   = 9'b000000100,
        S_SQSUM = 9'b000001000,
        S_ROOT  = 9'b000010000,
        S_MULX  = 9'b000100000,
        S_MULY  = 9'b001000000,
        S_ACCY  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.seg ? S_SQX : S_FIN;
                end
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state = S_SQSUM;
            end
            S_SQSUM: begin
                o_cmd.sq_sum = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_sts.root_last) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state = S_MULY;
            end
            S_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state = S_ACCY;
            end
            S_ACCY: begin
                o_cmd.acc_y = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// File: sv/pwcs_datapath.sv
// coordinate registers, shared multiplier, bit-serial root and saturating accumulators
`default_nettype none
module pwcs_datapath #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pwcs_pkg::t_dp_cmd                   i_cmd,
    output pwcs_pkg::t_dp_sts                        o_sts,
    input  wire logic signed [pwcs_pkg::XY_W-1:0]    i_x,
    input  wire logic signed [pwcs_pkg::XY_W-1:0]    i_y,
    input  wire logic                                i_start_line,
    input  wire logic                                i_clear_sums,
    output logic        [pwcs_pkg::LEN_W-1:0]        o_total_length,
    output logic signed [pwcs_pkg::ACC_W-1:0]        o_weighted_x,
    output logic signed [pwcs_pkg::ACC_W-1:0]        o_weighted_y,
    output logic                                     o_overflowed
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;          // difference and sum width
    localparam int RB    = CB + 1;          // root width
    localparam int SQW   = 2 * CB;          // one square
    localparam int RADW  = 2 * RB;          // radicand
    localparam int REMW  = RB + 2;          // root remainder
    localparam int OW    = CB + 2;          // multiplier operand
    localparam int PW    = 2 * OW;          // product
    localparam int LEN_W = pwcs_pkg::LEN_W;
    localparam int ACC_W = pwcs_pkg::ACC_W;
    localparam int AW    = ((PW > ACC_W) ? PW : ACC_W) + 1;
    localparam int CNTW  = $clog2(RB);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [CB-1:0]    r_prev_x, r_prev_y;
    logic                    r_have_prev;
    logic        [LEN_W-1:0] r_len;
    logic signed [ACC_W-1:0] r_wx, r_wy;
    logic                    r_sat;

    logic        [CB-1:0]    r_ax, r_ay;
    logic signed [DW-1:0]    r_sx, r_sy;
    logic signed [PW-1:0]    r_prod;
    logic        [SQW-1:0]   r_sq;
    logic        [RADW-1:0]  r_rad;
    logic        [REMW-1:0]  r_rem;
    logic        [RB-1:0]    r_root;
    logic        [CNTW-1:0]  r_cnt;

    logic        [LEN_W-1:0] r_out_len;
    logic signed [ACC_W-1:0] r_out_wx, r_out_wy;
    logic                    r_out_sat;

    // input coordinates reduced to COORD_BITS and sign extended by one bit
    logic signed [CB-1:0]    x_c, y_c;
    logic signed [DW-1:0]    dx, dy, ndx, ndy, sx, sy;

    logic signed [OW-1:0]    mul_a, mul_b;
    logic        [RADW-1:0]  rad_sum;
    logic        [REMW-1:0]  rem_sh, trial;
    logic                    rem_ge;
    logic        [LEN_W:0]   len_sum;
    logic signed [ACC_W-1:0] acc_in, acc_res;
    logic signed [AW-1:0]    acc_sum;
    logic                    acc_fit;

    assign x_c = i_x[CB-1:0];
    assign y_c = i_y[CB-1:0];
    assign dx  = {r_prev_x[CB-1], r_prev_x} - {x_c[CB-1], x_c};
    assign dy  = {r_prev_y[CB-1], r_prev_y} - {y_c[CB-1], y_c};
    assign ndx = -dx;
    assign ndy = -dy;
    assign sx  = {r_prev_x[CB-1], r_prev_x} + {x_c[CB-1], x_c};
    assign sy  = {r_prev_y[CB-1], r_prev_y} + {y_c[CB-1], y_c};

    assign o_sts.seg       = !i_start_line && r_have_prev;
    assign o_sts.root_last = (r_cnt == '0);

    // shared multiplier operand select
    always_comb begin
        priority if (i_cmd.sq_x) begin
            mul_a = {2'b00, r_ax};
            mul_b = {2'b00, r_ax};
        end else if (i_cmd.sq_y) begin
            mul_a = {2'b00, r_ay};
            mul_b = {2'b00, r_ay};
        end else if (i_cmd.mul_x) begin
            mul_a = {r_sx[DW-1], r_sx};
            mul_b = {1'b0, r_root};
        end else begin
            mul_a = {r_sy[DW-1], r_sy};
            mul_b = {1'b0, r_root};
        end
    end

    assign rad_sum = {2'b00, r_sq} + {2'b00, r_prod[SQW-1:0]};

    // one root bit per step
    assign rem_sh = {r_rem[REMW-3:0], r_rad[RADW-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign rem_ge = (rem_sh >= trial);

    assign len_sum = {1'b0, r_len} + {{(LEN_W + 1 - RB){1'b0}}, r_root};

    // exact add then clamp to the signed 64-bit range
    assign acc_in  = i_cmd.acc_y ? r_wy : r_wx;
    assign acc_sum = {{(AW-ACC_W){acc_in[ACC_W-1]}}, acc_in}
                   + {{(AW-PW){r_prod[PW-1]}}, r_prod};
    assign acc_fit = (&acc_sum[AW-1:ACC_W-1]) || !(|acc_sum[AW-1:ACC_W-1]);
    assign acc_res = acc_fit ? acc_sum[ACC_W-1:0]
                             : (acc_sum[AW-1] ? ACC_MIN : ACC_MAX);

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_len       <= '0;
            r_wx        <= '0;
            r_wy        <= '0;
            r_sat       <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_prev_x    <= x_c;
                r_prev_y    <= y_c;
                r_have_prev <= 1'b1;
                if (i_clear_sums) begin
                    r_len <= '0;
                    r_wx  <= '0;
                    r_wy  <= '0;
                    r_sat <= 1'b0;
                end
            end
            if (i_cmd.mul_x) begin
                if (len_sum[LEN_W]) begin
                    r_len <= '1;
                    r_sat <= 1'b1;
                end else begin
                    r_len <= len_sum[LEN_W-1:0];
                end
            end
            if (i_cmd.mul_y) begin
                r_wx <= acc_res;
                if (!acc_fit) begin
                    r_sat <= 1'b1;
                end
            end
            if (i_cmd.acc_y) begin
                r_wy <= acc_res;
                if (!acc_fit) begin
                    r_sat <= 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ax <= dx[DW-1] ? ndx[CB-1:0] : dx[CB-1:0];
            r_ay <= dy[DW-1] ? ndy[CB-1:0] : dy[CB-1:0];
            r_sx <= sx;
            r_sy <= sy;
        end
        if (i_cmd.sq_x || i_cmd.sq_y || i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.sq_y) begin
            r_sq <= r_prod[SQW-1:0];
        end
        if (i_cmd.sq_sum) begin
            r_rad  <= rad_sum;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNTW'(RB - 1);
        end
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[RADW-3:0], 2'b00};
            r_cnt <= r_cnt - 1'b1;
            if (rem_ge) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[RB-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[RB-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_out_len <= r_len;
            r_out_wx  <= r_wx;
            r_out_wy  <= r_wy;
            r_out_sat <= r_sat;
        end
    end

    assign o_total_length = r_out_len;
    assign o_weighted_x   = r_out_wx;
    assign o_weighted_y   = r_out_wy;
    assign o_overflowed   = r_out_sat;

endmodule
`default_nettype wire

// File: sv/polyline_weighted_centroid_sums.sv
// top level of the polyline length-weighted centroid sums block
// Takes one polyline vertex per transaction on i_vtx and returns one result
// transaction on o_sum holding the running total length, the two
// length-weighted coordinate sums and the sticky overflow flag. Only the low
// COORD_BITS bits of x and y are used, sign extended. A vertex flagged
// start_line, or the first vertex after reset, only becomes the previous
// vertex; every other vertex forms a segment whose length is the floor
// square root of dx^2+dy^2. clear_sums zeroes the sums and the flag before
// the vertex is applied and leaves the previous vertex alone. One item is
// worked at a time: a vertex that forms no segment goes from acceptance
// straight to the result load; a segment runs through the two squares, the
// bit-serial square root, which produces one root bit per cycle over
// COORD_BITS+1 bits, and the two products, making four passes through the
// single shared multiplier. The result sits in an output register, so the
// next vertex is taken while a result still waits on o_sum.
`default_nettype none
module polyline_weighted_centroid_sums #(
    parameter int COORD_BITS = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pwcs_in_if.sink      i_vtx,
    pwcs_out_if.source   o_sum
);

    pwcs_pkg::t_dp_cmd w_cmd;
    pwcs_pkg::t_dp_sts w_sts;

    // sequencer: accept, two squares, their sum, root steps, two products, y accumulate, result load
    pwcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vtx.valid),
        .o_in_ready  (i_vtx.ready),
        .o_out_valid (o_sum.valid),
        .i_out_ready (o_sum.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // arithmetic, running sums and the result register
    pwcs_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_x            (i_vtx.x),
        .i_y            (i_vtx.y),
        .i_start_line   (i_vtx.start_line),
        .i_clear_sums   (i_vtx.clear_sums),
        .o_total_length (o_sum.total_length),
        .o_weighted_x   (o_sum.weighted_x),
        .o_weighted_y   (o_sum.weighted_y),
        .o_overflowed   (o_sum.overflowed)
    );

endmodule
`default_nettype wire

// File: sv/pwcs_checker.sv
// port-level checks for the centroid sums block and their bind
`default_nettype none
module pwcs_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic        [pwcs_pkg::LEN_W-1:0] i_total_length,
    input wire logic signed [pwcs_pkg::ACC_W-1:0] i_weighted_x,
    input wire logic signed [pwcs_pkg::ACC_W-1:0] i_weighted_y,
    input wire logic                              i_overflowed
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_total_length)
            && $stable(i_weighted_x) && $stable(i_weighted_y) && $stable(i_overflowed)))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("new transaction taken while an item is in work");

    // a result never shows up in the cycle right after its vertex
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result appeared too early");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind polyline_weighted_centroid_sums pwcs_checker u_pwcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_vtx.valid),
    .i_in_ready     (i_vtx.ready),
    .i_out_valid    (o_sum.valid),
    .i_out_ready    (o_sum.ready),
    .i_total_length (o_sum.total_length),
    .i_weighted_x   (o_sum.weighted_x),
    .i_weighted_y   (o_sum.weighted_y),
    .i_overflowed   (o_sum.overflowed)
);
`default_nettype wire
